@@ design/vws_pkg.sv @@
// Shared constants, types and arithmetic helpers of the vocal waveguide step.
package vws_pkg;

    localparam int ORAL_DEF  = 44;
    localparam int NASAL_DEF = 28;

    localparam int WAVE_W  = 24;
    localparam int COEF_W  = 17;
    localparam int GAIN_W  = 17;
    localparam int JW      = 27;
    localparam int MUL_A_W = 27;
    localparam int MUL_B_W = 18;
    localparam int PROD_W  = 45;
    localparam int RND_W   = PROD_W - 16;
    localparam int IDX_W   = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    localparam logic [GAIN_W-1:0] ONE_Q16  = 17'd65536;
    localparam logic [GAIN_W-1:0] DAMP_Q16 = 17'd65470;

    localparam logic signed [COEF_W-1:0] GLOTTIS_RST = 17'sd49152;
    localparam logic signed [COEF_W-1:0] LIP_RST     = -17'sd55706;
    localparam logic [GAIN_W-1:0]        FADE_RST    = 17'd65536;
    localparam logic [IDX_W-1:0]         BRANCH_RST  = 6'd17;

    localparam logic [1:0] FUNC_SAMPLE = 2'd0;
    localparam logic [1:0] FUNC_ORAL   = 2'd1;
    localparam logic [1:0] FUNC_JUNC   = 2'd2;
    localparam logic [1:0] FUNC_NASAL  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_GLOTTIS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIP     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FADE    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BRANCH  = 2'd3;

    // junction unit step codes
    localparam logic [3:0] JS_GLOTTIS  = 4'd0;
    localparam logic [3:0] JS_LIP      = 4'd1;
    localparam logic [3:0] JS_NOSE     = 4'd2;
    localparam logic [3:0] JS_BLEND_A0 = 4'd3;
    localparam logic [3:0] JS_BLEND_B0 = 4'd4;
    localparam logic [3:0] JS_MIX0     = 4'd5;
    localparam logic [3:0] JS_BLEND_A1 = 4'd6;
    localparam logic [3:0] JS_BLEND_B1 = 4'd7;
    localparam logic [3:0] JS_MIX1     = 4'd8;
    localparam logic [3:0] JS_BLEND_A2 = 4'd9;
    localparam logic [3:0] JS_BLEND_B2 = 4'd10;
    localparam logic [3:0] JS_MIX2     = 4'd11;
    localparam logic [3:0] JS_LAST     = JS_MIX2;

    typedef enum logic [2:0] {
        CS_HOLD,
        CS_BLEND_A,
        CS_BLEND_B,
        CS_SCATTER,
        CS_DAMP_R,
        CS_DAMP_L
    } cell_step_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_JUNC,
        ST_CELL,
        ST_DONE
    } ctl_state_t;

    typedef struct packed {
        logic                     en;
        logic                     direct;
        logic signed [COEF_W-1:0] value;
    } coef_wr_t;

    // round half up, then drop 16 fraction bits
    function automatic logic signed [RND_W-1:0] rnd16(input logic signed [PROD_W-1:0] x);
        logic signed [PROD_W-1:0] y;
        y = x + PROD_W'(32768);
        return y[PROD_W-1:16];
    endfunction

    function automatic logic signed [WAVE_W-1:0] sat24(input logic signed [RND_W-1:0] x);
        logic signed [RND_W-1:0] hi;
        logic signed [RND_W-1:0] lo;
        hi = RND_W'(8388607);
        lo = -RND_W'(8388608);
        if (x > hi)
            return 24'sh7FFFFF;
        else if (x < lo)
            return 24'sh800000;
        else
            return x[WAVE_W-1:0];
    endfunction

    function automatic logic [GAIN_W-1:0] gain_clip(input logic [GAIN_W-1:0] v);
        return (v > ONE_Q16) ? ONE_Q16 : v;
    endfunction

endpackage

@@ design/vws_if.sv @@
// Handshake channels of the vocal waveguide step: sample/command items and results.
interface vws_item_if
    import vws_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [1:0]               func;
    logic signed [WAVE_W-1:0] glottal_sample;
    logic [GAIN_W-1:0]        blend;
    logic [IDX_W-1:0]         coef_index;
    logic signed [COEF_W-1:0] coef_value;

    modport source (output valid, func, glottal_sample, blend, coef_index, coef_value,
                    input ready);
    modport sink (input valid, func, glottal_sample, blend, coef_index, coef_value,
                  output ready);
endinterface

interface vws_result_if
    import vws_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [WAVE_W-1:0] lip_sample;
    logic signed [WAVE_W-1:0] nose_sample;

    modport source (output valid, lip_sample, nose_sample, input ready);
    modport sink (input valid, lip_sample, nose_sample, output ready);
endinterface

@@ design/vws_cell.sv @@
// One waveguide section: holds its waves and coefficients, scatters and damps.
module vws_cell
    import vws_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cell_step_t               step,
    input  coef_wr_t                 cwr,
    input  logic [GAIN_W-1:0]        lam,
    input  logic [GAIN_W-1:0]        gain,
    input  logic signed [WAVE_W-1:0] rw_prev,
    input  logic signed [JW-1:0]     jr_in,
    input  logic signed [JW-1:0]     jl_in,
    output logic signed [WAVE_W-1:0] rw,
    output logic signed [WAVE_W-1:0] lw,
    output logic signed [JW-1:0]     jr,
    output logic signed [JW-1:0]     jl
);

    logic signed [WAVE_W-1:0]  rw_reg, lw_reg;
    logic signed [COEF_W-1:0]  old_reg, new_reg;
    logic signed [PROD_W-1:0]  acc_reg;
    logic signed [MUL_B_W-1:0] r_reg;
    logic signed [JW-1:0]      jr_reg, jl_reg;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod;
    logic signed [PROD_W-1:0]  blend_sum;
    logic signed [RND_W-1:0]   rnd;
    logic signed [RND_W-1:0]   blend_rnd;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (step)
            CS_BLEND_A:
            begin
                mul_a = MUL_A_W'(old_reg);
                mul_b = $signed({1'b0, ONE_Q16 - lam});
            end
            CS_BLEND_B:
            begin
                mul_a = MUL_A_W'(new_reg);
                mul_b = $signed({1'b0, lam});
            end
            CS_SCATTER:
            begin
                mul_a = MUL_A_W'(rw_prev) + MUL_A_W'(lw_reg);
                mul_b = r_reg;
            end
            CS_DAMP_R:
            begin
                mul_a = MUL_A_W'(jr_in);
                mul_b = $signed({1'b0, gain});
            end
            CS_DAMP_L:
            begin
                mul_a = MUL_A_W'(jl_in);
                mul_b = $signed({1'b0, gain});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod      = PROD_W'(mul_a) * PROD_W'(mul_b);
        rnd       = rnd16(prod);
        blend_sum = acc_reg + prod;
        blend_rnd = rnd16(blend_sum);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rw_reg  <= '0;
            lw_reg  <= '0;
            old_reg <= '0;
            new_reg <= '0;
        end
        else
        begin
            if (cwr.en)
            begin
                old_reg <= cwr.direct ? cwr.value : new_reg;
                new_reg <= cwr.value;
            end
            if (step == CS_DAMP_R)
                rw_reg <= sat24(rnd);
            if (step == CS_DAMP_L)
                lw_reg <= sat24(rnd);
        end
    end

    always_ff @(posedge clk)
    begin
        if (step == CS_BLEND_A)
            acc_reg <= prod;
        if (step == CS_BLEND_B)
            r_reg <= blend_rnd[MUL_B_W-1:0];
        if (step == CS_SCATTER)
        begin
            jr_reg <= JW'(rw_prev) - rnd[JW-1:0];
            jl_reg <= JW'(lw_reg) + rnd[JW-1:0];
        end
    end

    assign rw = rw_reg;
    assign lw = lw_reg;
    assign jr = jr_reg;
    assign jl = jl_reg;

endmodule

@@ design/vws_junc.sv @@
// End reflections and three-port nasal branch junction on one shared multiplier.
module vws_junc
    import vws_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     run,
    input  logic [3:0]               step,
    input  coef_wr_t                 cwr,
    input  logic [1:0]               csel,
    input  logic [GAIN_W-1:0]        lam,
    input  logic signed [COEF_W-1:0] glr,
    input  logic signed [COEF_W-1:0] lpr,
    input  logic signed [WAVE_W-1:0] gs,
    input  logic signed [WAVE_W-1:0] lw0,
    input  logic signed [WAVE_W-1:0] rw_last,
    input  logic signed [WAVE_W-1:0] nrw_last,
    input  logic signed [WAVE_W-1:0] li,
    input  logic signed [WAVE_W-1:0] rp,
    input  logic signed [WAVE_W-1:0] nl0,
    output logic signed [JW-1:0]     gt,
    output logic signed [JW-1:0]     lt,
    output logic signed [JW-1:0]     nlt,
    output logic signed [JW-1:0]     jlb,
    output logic signed [JW-1:0]     jrb,
    output logic signed [JW-1:0]     njr0
);

    logic signed [COEF_W-1:0]  jc_reg [6];
    logic signed [JW-1:0]      gt_reg, lt_reg, nlt_reg, s_reg;
    logic signed [JW-1:0]      out_reg [3];
    logic signed [PROD_W-1:0]  acc_reg;
    logic signed [MUL_B_W-1:0] r_reg;

    logic [1:0]                k;
    logic                      is_a, is_b, is_mix;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod, blend_sum;
    logic signed [RND_W-1:0]   rnd, blend_rnd;
    logic signed [JW-1:0]      y [3];

    always_comb
    begin
        k      = 2'd0;
        is_a   = 1'b0;
        is_b   = 1'b0;
        is_mix = 1'b0;
        case (step)
            JS_BLEND_A0: begin k = 2'd0; is_a = 1'b1; end
            JS_BLEND_B0: begin k = 2'd0; is_b = 1'b1; end
            JS_MIX0:     begin k = 2'd0; is_mix = 1'b1; end
            JS_BLEND_A1: begin k = 2'd1; is_a = 1'b1; end
            JS_BLEND_B1: begin k = 2'd1; is_b = 1'b1; end
            JS_MIX1:     begin k = 2'd1; is_mix = 1'b1; end
            JS_BLEND_A2: begin k = 2'd2; is_a = 1'b1; end
            JS_BLEND_B2: begin k = 2'd2; is_b = 1'b1; end
            JS_MIX2:     begin k = 2'd2; is_mix = 1'b1; end
            default:     begin k = 2'd0; end
        endcase

        y[0] = JW'(nl0) + JW'(li);
        y[1] = JW'(rp) + JW'(nl0);
        y[2] = JW'(li) + JW'(rp);

        mul_a = '0;
        mul_b = '0;
        if (step == JS_GLOTTIS)
        begin
            mul_a = MUL_A_W'(lw0);
            mul_b = MUL_B_W'(glr);
        end
        else if (step == JS_LIP)
        begin
            mul_a = MUL_A_W'(rw_last);
            mul_b = MUL_B_W'(lpr);
        end
        else if (step == JS_NOSE)
        begin
            mul_a = MUL_A_W'(nrw_last);
            mul_b = MUL_B_W'(lpr);
        end
        else if (is_a)
        begin
            // new coefficient weighted by one minus blend
            mul_a = MUL_A_W'(jc_reg[{k, 1'b1}]);
            mul_b = $signed({1'b0, ONE_Q16 - lam});
        end
        else if (is_b)
        begin
            mul_a = MUL_A_W'(jc_reg[{k, 1'b0}]);
            mul_b = $signed({1'b0, lam});
        end
        else if (is_mix)
        begin
            mul_a = s_reg;
            mul_b = r_reg;
        end
        prod      = PROD_W'(mul_a) * PROD_W'(mul_b);
        rnd       = rnd16(prod);
        blend_sum = acc_reg + prod;
        blend_rnd = rnd16(blend_sum);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
                jc_reg[i] <= '0;
        end
        else if (cwr.en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (csel == 2'(i))
                begin
                    jc_reg[2 * i]     <= jc_reg[2 * i + 1];
                    jc_reg[2 * i + 1] <= cwr.value;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (run)
        begin
            if (step == JS_GLOTTIS)
            begin
                gt_reg <= rnd[JW-1:0] + JW'(gs);
                s_reg  <= JW'(rp) + JW'(li) + JW'(nl0);
            end
            if (step == JS_LIP)
                lt_reg <= rnd[JW-1:0];
            if (step == JS_NOSE)
                nlt_reg <= rnd[JW-1:0];
            if (is_a)
                acc_reg <= prod;
            if (is_b)
                r_reg <= blend_rnd[MUL_B_W-1:0];
            if (is_mix)
                out_reg[k] <= y[k] + rnd[JW-1:0];
        end
    end

    assign gt   = gt_reg;
    assign lt   = lt_reg;
    assign nlt  = nlt_reg;
    assign jlb  = out_reg[0];
    assign jrb  = out_reg[1];
    assign njr0 = out_reg[2];

endmodule

@@ design/vocal_waveguide_step.sv @@
// Top level: oral and nasal cell rows, branch junction unit and control.
//
//  channel  | role      | payload
//  ---------+-----------+-----------------------------------------------------
//  item     | sink      | func, glottal_sample, blend, coef_index, coef_value
//  result   | source    | lip_sample, nose_sample
//  cfg      | write     | cfg_we, cfg_index, cfg_data
//
// A sample's result is loaded after 12 steps of the junction unit's shared multiplier and
// 5 steps in which every cell blends, scatters and damps in parallel; no item is taken
// until that load, which waits while an earlier result is still held. Reset clears the
// stored waves and the cell and junction coefficients; the config registers get reset values.
// A waiting result holds in its output register while the next item is taken; a new
// result waits until it leaves.
module vocal_waveguide_step
    import vws_pkg::*;
#(
    parameter int ORAL_SECTIONS  = ORAL_DEF,
    parameter int NASAL_SECTIONS = NASAL_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    vws_item_if.sink              item,
    vws_result_if.source          result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam logic [IDX_W-1:0] LAST_ORAL = IDX_W'(ORAL_SECTIONS - 1);

    logic signed [COEF_W-1:0] glr_reg, lpr_reg;
    logic [GAIN_W-1:0]        fade_reg;
    logic [IDX_W-1:0]         branch_reg;
    logic signed [WAVE_W-1:0] gs_reg;
    logic [GAIN_W-1:0]        lam_reg;

    ctl_state_t state_reg, state_next;
    cell_step_t cs_reg, cs_next;
    logic [3:0] step_reg, step_next;

    logic                     res_valid_reg, res_valid_next;
    logic signed [WAVE_W-1:0] lip_reg, nose_reg;
    logic                     load;

    logic       accept;
    logic [IDX_W-1:0] bc;
    logic [GAIN_W-1:0] fade;

    logic signed [WAVE_W-1:0] rw_w [ORAL_SECTIONS];
    logic signed [WAVE_W-1:0] lw_w [ORAL_SECTIONS];
    logic signed [JW-1:0]     jr_w [ORAL_SECTIONS];
    logic signed [JW-1:0]     jl_w [ORAL_SECTIONS];
    logic signed [WAVE_W-1:0] nrw_w [NASAL_SECTIONS];
    logic signed [WAVE_W-1:0] nlw_w [NASAL_SECTIONS];
    logic signed [JW-1:0]     njr_w [NASAL_SECTIONS];
    logic signed [JW-1:0]     njl_w [NASAL_SECTIONS];

    logic signed [WAVE_W-1:0] li, rp;
    logic signed [JW-1:0]     gt, lt, nlt, jlb, jrb, njr0;
    coef_wr_t                 jwr;

    assign accept      = item.valid && item.ready;
    assign item.ready  = (state_reg == ST_IDLE);
    assign fade        = gain_clip(fade_reg);

    always_comb
    begin
        if (branch_reg == '0)
            bc = IDX_W'(1);
        else if (branch_reg > LAST_ORAL)
            bc = LAST_ORAL;
        else
            bc = branch_reg;
    end

    always_comb
    begin
        li = '0;
        rp = '0;
        for (int i = 0; i < ORAL_SECTIONS; i++)
        begin
            if (IDX_W'(i) == bc)
                li = lw_w[i];
            if (IDX_W'(i + 1) == bc)
                rp = rw_w[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            glr_reg    <= GLOTTIS_RST;
            lpr_reg    <= LIP_RST;
            fade_reg   <= FADE_RST;
            branch_reg <= BRANCH_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_GLOTTIS: glr_reg    <= $signed(cfg_data[COEF_W-1:0]);
                REG_LIP:     lpr_reg    <= $signed(cfg_data[COEF_W-1:0]);
                REG_FADE:    fade_reg   <= cfg_data[GAIN_W-1:0];
                REG_BRANCH:  branch_reg <= cfg_data[IDX_W-1:0];
                default:     fade_reg   <= fade_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && item.func == FUNC_SAMPLE)
        begin
            gs_reg  <= item.glottal_sample;
            lam_reg <= gain_clip(item.blend);
        end
        if (load)
        begin
            lip_reg  <= rw_w[ORAL_SECTIONS-1];
            nose_reg <= nrw_w[NASAL_SECTIONS-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cs_reg        <= CS_HOLD;
            step_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cs_reg        <= cs_next;
            step_reg      <= step_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cs_next    = cs_reg;
        step_next  = step_reg;
        load       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && item.func == FUNC_SAMPLE)
                begin
                    state_next = ST_JUNC;
                    step_next  = JS_GLOTTIS;
                end
            end
            ST_JUNC:
            begin
                step_next = step_reg + 4'd1;
                if (step_reg == JS_LAST)
                begin
                    state_next = ST_CELL;
                    cs_next    = CS_BLEND_A;
                end
            end
            ST_CELL:
            begin
                unique case (cs_reg)
                    CS_BLEND_A: cs_next = CS_BLEND_B;
                    CS_BLEND_B: cs_next = CS_SCATTER;
                    CS_SCATTER: cs_next = CS_DAMP_R;
                    CS_DAMP_R:  cs_next = CS_DAMP_L;
                    default:
                    begin
                        cs_next    = CS_HOLD;
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_DONE:
            begin
                if (!res_valid_reg || result.ready)
                begin
                    load       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (load)
            res_valid_next = 1'b1;
        else if (result.ready)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    assign result.valid       = res_valid_reg;
    assign result.lip_sample  = lip_reg;
    assign result.nose_sample = nose_reg;

    assign jwr.en     = accept && item.func == FUNC_JUNC && item.coef_index < IDX_W'(3);
    assign jwr.direct = 1'b0;
    assign jwr.value  = item.coef_value;

    vws_junc u_junc (
        .clk      (clk),
        .rst_n    (rst_n),
        .run      (state_reg == ST_JUNC),
        .step     (step_reg),
        .cwr      (jwr),
        .csel     (item.coef_index[1:0]),
        .lam      (lam_reg),
        .glr      (glr_reg),
        .lpr      (lpr_reg),
        .gs       (gs_reg),
        .lw0      (lw_w[0]),
        .rw_last  (rw_w[ORAL_SECTIONS-1]),
        .nrw_last (nrw_w[NASAL_SECTIONS-1]),
        .li       (li),
        .rp       (rp),
        .nl0      (nlw_w[0]),
        .gt       (gt),
        .lt       (lt),
        .nlt      (nlt),
        .jlb      (jlb),
        .jrb      (jrb),
        .njr0     (njr0)
    );

    for (genvar i = 0; i < ORAL_SECTIONS; i++)
    begin : g_oral
        coef_wr_t                 cwr;
        logic signed [WAVE_W-1:0] rw_prev;
        logic signed [JW-1:0]     jr_sel, jl_sel;

        assign cwr.en     = accept && item.func == FUNC_ORAL && item.coef_index == IDX_W'(i);
        assign cwr.direct = 1'b0;
        assign cwr.value  = item.coef_value;

        if (i == 0)
        begin : g_first
            assign rw_prev = '0;
            assign jr_sel  = gt;
        end
        else
        begin : g_rest
            assign rw_prev = rw_w[i-1];
            assign jr_sel  = (IDX_W'(i) == bc) ? jrb : jr_w[i];
        end

        if (i == ORAL_SECTIONS - 1)
        begin : g_last
            assign jl_sel = lt;
        end
        else
        begin : g_inner
            assign jl_sel = (IDX_W'(i + 1) == bc) ? jlb : jl_w[i+1];
        end

        vws_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .step    (cs_reg),
            .cwr     (cwr),
            .lam     (lam_reg),
            .gain    (DAMP_Q16),
            .rw_prev (rw_prev),
            .jr_in   (jr_sel),
            .jl_in   (jl_sel),
            .rw      (rw_w[i]),
            .lw      (lw_w[i]),
            .jr      (jr_w[i]),
            .jl      (jl_w[i])
        );
    end

    for (genvar i = 0; i < NASAL_SECTIONS; i++)
    begin : g_nasal
        coef_wr_t                 cwr;
        logic signed [WAVE_W-1:0] rw_prev;
        logic signed [JW-1:0]     jr_sel, jl_sel;

        assign cwr.en     = accept && item.func == FUNC_NASAL && item.coef_index == IDX_W'(i);
        assign cwr.direct = 1'b1;
        assign cwr.value  = item.coef_value;

        if (i == 0)
        begin : g_first
            assign rw_prev = '0;
            assign jr_sel  = njr0;
        end
        else
        begin : g_rest
            assign rw_prev = nrw_w[i-1];
            assign jr_sel  = njr_w[i];
        end

        if (i == NASAL_SECTIONS - 1)
        begin : g_last
            assign jl_sel = nlt;
        end
        else
        begin : g_inner
            assign jl_sel = njl_w[i+1];
        end

        vws_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .step    (cs_reg),
            .cwr     (cwr),
            .lam     (lam_reg),
            .gain    (fade),
            .rw_prev (rw_prev),
            .jr_in   (jr_sel),
            .jl_in   (jl_sel),
            .rw      (nrw_w[i]),
            .lw      (nlw_w[i]),
            .jr      (njr_w[i]),
            .jl      (njl_w[i])
        );
    end

endmodule
